@@ rtl/hfr_crc_pkg.sv @@
// ----------------------------------------------------------------------------
// hfr_crc_pkg - shared definitions for the hex frame receiver
// Sizes, register map, status codes, the CRC-16 step and the hex digit decoder.
// ----------------------------------------------------------------------------
package hfr_crc_pkg;

  // Frame limits and the widths that follow from them.
  localparam int unsigned MAX_CHARS   = 50;
  localparam int unsigned MAX_DECODED = 25;
  localparam int unsigned CNT_W       = $clog2(MAX_CHARS + 1);
  localparam int unsigned IDX_W       = $clog2(MAX_DECODED);
  localparam int unsigned M_W         = $clog2(MAX_DECODED + 1);

  // Register map, indexed by word address.
  localparam logic [1:0] REG_START_BYTE = 2'd0;
  localparam logic [1:0] REG_END_BYTE   = 2'd1;
  localparam logic [1:0] REG_CRC_SEED   = 2'd2;

  localparam logic [7:0]  START_BYTE_RST = 8'h01;
  localparam logic [7:0]  END_BYTE_RST   = 8'h17;
  localparam logic [15:0] CRC_SEED_RST   = 16'hC0C1;

  // Reflected CRC-16 polynomial; one bit per step gives the same result as
  // the byte-wide parity form with pattern 0xC001.
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Result status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_LEN     = 3'd1;
  localparam logic [2:0] ST_HEX     = 3'd2;
  localparam logic [2:0] ST_CRC     = 3'd3;
  localparam logic [2:0] ST_OVF     = 3'd4;
  localparam logic [2:0] ST_STRAY   = 3'd5;
  localparam logic [2:0] ST_TIMEOUT = 3'd6;

  // Decode one character as ((c | 0x20) mod 39) - 9, modulo 256; 0x00 as 0.
  // The mod is a multiply by a reciprocal (105/4096) and one correction step.
  function automatic logic [7:0] hex_decode(input logic [7:0] c);
    logic [7:0]  x;
    logic [14:0] prod;
    logic [2:0]  quot;
    logic [7:0]  rem;
    x    = c | 8'h20;
    prod = 15'(x) * 15'd105;
    quot = prod[14:12];
    rem  = x - 8'(quot * 3'd7 + 8'(quot) * 8'd32);
    if (rem >= 8'd39) begin
      rem = rem - 8'd39;
    end
    if (c == 8'h00) begin
      hex_decode = 8'h00;
    end else begin
      hex_decode = rem - 8'd9;
    end
  endfunction

  // One bit step of the reflected CRC-16.
  function automatic logic [15:0] crc_bit_step(input logic [15:0] crc);
    if (crc[0]) begin
      crc_bit_step = (crc >> 1) ^ CRC_POLY;
    end else begin
      crc_bit_step = crc >> 1;
    end
  endfunction

endpackage

@@ rtl/hex_frame_receiver_crc_check_unit.sv @@
// ----------------------------------------------------------------------------
// hex_frame_receiver_crc_check_unit - hex ASCII frame receiver with CRC check
// Collects hex characters between start and end bytes, checks length, digits
// and the CRC-16, and emits the decoded bytes or one error status.
// ----------------------------------------------------------------------------
// A character beat outside a frame, a timeout beat or a character whose CRC
// delay line is still filling leaves the sequencer idle. From the fifth
// character of a frame on, the character four places back is folded into
// the CRC by a shared one-bit shift unit, so that beat runs 8 CRC steps in
// S_CRC before the next beat is taken. An end byte with a good length and
// good digits reads the two checksum bytes from the decode store, compares
// them, then emits each decoded byte with one store read and one output
// load, or gives a checksum error. The single read port of the decode store
// sets the emit rate. Length and digit errors, overflow, stray bytes and
// timeouts in a frame give their single result in the beat's own cycle.
// Output backpressure stalls the beats and result loads; a new beat is taken
// while a result waits, if the output register is freed in that same cycle.

module hex_frame_receiver_crc_check_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  byte_value_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  data_byte_o,
  output logic [4:0]  byte_index_o,
  output logic [2:0]  status_o,
  output logic        last_o
);

  localparam int unsigned CW = hfr_crc_pkg::CNT_W;
  localparam int unsigned IW = hfr_crc_pkg::IDX_W;
  localparam int unsigned MW = hfr_crc_pkg::M_W;

  // Sequencer states.
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CRC     = 3'd1;
  localparam logic [2:0] S_CHK_HI  = 3'd2;
  localparam logic [2:0] S_CHK_CMP = 3'd3;
  localparam logic [2:0] S_ERR     = 3'd4;
  localparam logic [2:0] S_EMIT_RD = 3'd5;
  localparam logic [2:0] S_EMIT_WR = 3'd6;

  // Configuration registers.
  logic [7:0]  start_byte_q;
  logic [7:0]  end_byte_q;
  logic [15:0] crc_seed_q;
  logic        cfg_wr;

  // Frame state.
  logic [2:0]    state_q, state_d;
  logic          in_frame_q, in_frame_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [3:0]    hi_nib_q, hi_nib_d;
  logic          hex_bad_q, hex_bad_d;
  logic [15:0]   crc_q, crc_d;
  logic [7:0]    dly_q [4];
  logic [7:0]    dly_d [4];
  logic [2:0]    step_q, step_d;
  logic [IW-1:0] k_q, k_d;
  logic [MW-1:0] m_q, m_d;
  logic [7:0]    lo_q, lo_d;
  logic [2:0]    err_q, err_d;

  // Decode store.
  logic [7:0]    mem [hfr_crc_pkg::MAX_DECODED];
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic [7:0]    rd_data_q;

  // Output register.
  logic       out_valid_q;
  logic [7:0] out_data_q;
  logic [4:0] out_index_q;
  logic [2:0] out_status_q;
  logic       out_last_q;
  logic       out_load;
  logic [7:0] ld_data;
  logic [4:0] ld_index;
  logic [2:0] ld_status;
  logic       ld_last;
  logic       out_free;

  // Helpers for the current beat.
  logic          accept;
  logic [7:0]    hex_v;
  logic [CW-2:0] pair_idx;
  logic [MW-1:0] m_now;
  logic          k_last;

  // Configuration writes and reads.
  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= hfr_crc_pkg::START_BYTE_RST;
      end_byte_q   <= hfr_crc_pkg::END_BYTE_RST;
      crc_seed_q   <= hfr_crc_pkg::CRC_SEED_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        hfr_crc_pkg::REG_START_BYTE: start_byte_q <= pwdata[7:0];
        hfr_crc_pkg::REG_END_BYTE:   end_byte_q   <= pwdata[7:0];
        hfr_crc_pkg::REG_CRC_SEED:   crc_seed_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      hfr_crc_pkg::REG_START_BYTE: prdata = {24'h0, start_byte_q};
      hfr_crc_pkg::REG_END_BYTE:   prdata = {24'h0, end_byte_q};
      hfr_crc_pkg::REG_CRC_SEED:   prdata = {16'h0, crc_seed_q};
      default:                     prdata = 32'h0;
    endcase
  end

  // Handshake and per-beat helpers.
  assign out_free   = ~out_valid_q | out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) & out_free;
  assign accept     = in_valid_i & in_ready_o;
  assign hex_v      = hfr_crc_pkg::hex_decode(byte_value_i);
  assign pair_idx   = cnt_q[CW-1:1];
  assign m_now      = MW'(pair_idx);
  assign k_last     = (MW'(k_q) + MW'(1)) == m_q;

  // Sequencer: frame collection, CRC steps, checksum compare and emission.
  always_comb begin
    state_d    = state_q;
    in_frame_d = in_frame_q;
    cnt_d      = cnt_q;
    hi_nib_d   = hi_nib_q;
    hex_bad_d  = hex_bad_q;
    crc_d      = crc_q;
    dly_d      = dly_q;
    step_d     = step_q;
    k_d        = k_q;
    m_d        = m_q;
    lo_d       = lo_q;
    err_d      = err_q;
    wr_en      = 1'b0;
    wr_addr    = IW'(pair_idx);
    wr_data    = {hi_nib_q, hex_v[3:0]};
    rd_en      = 1'b0;
    rd_addr    = k_q;
    out_load   = 1'b0;
    ld_data    = 8'h00;
    ld_index   = 5'd0;
    ld_status  = hfr_crc_pkg::ST_OK;
    ld_last    = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (kind_i) begin
            // Timeout drops an open frame with a timeout status; outside a frame it has no effect.
            if (in_frame_q) begin
              in_frame_d = 1'b0;
              out_load   = 1'b1;
              ld_status  = hfr_crc_pkg::ST_TIMEOUT;
            end
          end else if (!in_frame_q) begin
            if (byte_value_i == start_byte_q) begin
              in_frame_d = 1'b1;
              cnt_d      = '0;
              hi_nib_d   = 4'h0;
              hex_bad_d  = 1'b0;
              crc_d      = crc_seed_q;
              for (int i = 0; i < 4; i++) begin
                dly_d[i] = 8'h00;
              end
            end else begin
              out_load  = 1'b1;
              ld_status = hfr_crc_pkg::ST_STRAY;
            end
          end else if (byte_value_i == end_byte_q) begin
            // Frame close: length, then digits, then the checksum.
            in_frame_d = 1'b0;
            m_d        = m_now;
            if (cnt_q < CW'(4) || cnt_q[0] ||
                int'(unsigned'(pair_idx)) > int'(hfr_crc_pkg::MAX_DECODED)) begin
              out_load  = 1'b1;
              ld_status = hfr_crc_pkg::ST_LEN;
            end else if (hex_bad_q) begin
              out_load  = 1'b1;
              ld_status = hfr_crc_pkg::ST_HEX;
            end else begin
              rd_en   = 1'b1;
              rd_addr = IW'(m_now - MW'(2));
              state_d = S_CHK_HI;
            end
          end else if (cnt_q >= CW'(hfr_crc_pkg::MAX_CHARS)) begin
            in_frame_d = 1'b0;
            out_load   = 1'b1;
            ld_status  = hfr_crc_pkg::ST_OVF;
          end else begin
            // Character beat: the byte four places back enters the CRC.
            if (cnt_q >= CW'(4)) begin
              crc_d   = crc_q ^ {8'h00, dly_q[3]};
              step_d  = 3'd0;
              state_d = S_CRC;
            end
            dly_d[3] = dly_q[2];
            dly_d[2] = dly_q[1];
            dly_d[1] = dly_q[0];
            dly_d[0] = byte_value_i;
            if (hex_v[7:4] != 4'h0) begin
              hex_bad_d = 1'b1;
            end
            if (!cnt_q[0]) begin
              hi_nib_d = hex_v[3:0];
            end else if (int'(unsigned'(pair_idx)) < int'(hfr_crc_pkg::MAX_DECODED)) begin
              wr_en = 1'b1;
            end
            cnt_d = cnt_q + CW'(1);
          end
        end
      end

      S_CRC: begin
        crc_d  = hfr_crc_pkg::crc_bit_step(crc_q);
        step_d = step_q + 3'd1;
        if (step_q == 3'd7) begin
          state_d = S_IDLE;
        end
      end

      S_CHK_HI: begin
        lo_d    = rd_data_q;
        rd_en   = 1'b1;
        rd_addr = IW'(m_q - MW'(1));
        state_d = S_CHK_CMP;
      end

      S_CHK_CMP: begin
        if ({rd_data_q, lo_q} != crc_q) begin
          err_d   = hfr_crc_pkg::ST_CRC;
          state_d = S_ERR;
        end else begin
          k_d     = '0;
          state_d = S_EMIT_RD;
        end
      end

      S_ERR: begin
        if (out_free) begin
          out_load  = 1'b1;
          ld_status = err_q;
          state_d   = S_IDLE;
        end
      end

      S_EMIT_RD: begin
        rd_en   = 1'b1;
        rd_addr = k_q;
        state_d = S_EMIT_WR;
      end

      S_EMIT_WR: begin
        if (out_free) begin
          out_load = 1'b1;
          ld_data  = rd_data_q;
          ld_index = 5'(k_q);
          ld_last  = k_last;
          if (k_last) begin
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + IW'(1);
            state_d = S_EMIT_RD;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control and frame state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_frame_q <= 1'b0;
      cnt_q      <= '0;
      hi_nib_q   <= 4'h0;
      hex_bad_q  <= 1'b0;
      crc_q      <= hfr_crc_pkg::CRC_SEED_RST;
      step_q     <= 3'd0;
      k_q        <= '0;
      m_q        <= '0;
      for (int i = 0; i < 4; i++) begin
        dly_q[i] <= 8'h00;
      end
    end else begin
      state_q    <= state_d;
      in_frame_q <= in_frame_d;
      cnt_q      <= cnt_d;
      hi_nib_q   <= hi_nib_d;
      hex_bad_q  <= hex_bad_d;
      crc_q      <= crc_d;
      step_q     <= step_d;
      k_q        <= k_d;
      m_q        <= m_d;
      dly_q      <= dly_d;
    end
  end

  // Payload holding registers.
  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    err_q <= err_d;
  end

  // Decode store, one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q   <= ld_data;
      out_index_q  <= ld_index;
      out_status_q <= ld_status;
      out_last_q   <= ld_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign data_byte_o  = out_data_q;
  assign byte_index_o = out_index_q;
  assign status_o     = out_status_q;
  assign last_o       = out_last_q;

endmodule
